// ----- hw/rtl/page_replacement_policy_top_macros.svh -----
// assertion helpers for the page replacement block
// both expect clk and arst_n in scope
`ifndef PAGE_REPLACEMENT_POLICY_TOP_MACROS_SVH
`define PAGE_REPLACEMENT_POLICY_TOP_MACROS_SVH

// same-cycle implication
`define PRP_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PRP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/prp_pkg.sv -----
`timescale 1ns / 1ps

package prp_pkg;

	localparam int DEFAULT_FRAMES = 8;

	localparam int PAGE_W     = 16;
	localparam int STAMP_W    = 32;
	localparam int USE_W      = 16;
	localparam int TOTAL_W    = 32;
	localparam int SLOT_W     = 3;
	localparam int POLICY_W   = 2;
	localparam int FIU_W      = 4;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 4;

	// result transaction: hit, slot, evicted_valid, evicted_page, hit_count, fault_count
	localparam int OUT_W       = 1 + SLOT_W + 1 + PAGE_W + TOTAL_W + TOTAL_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_W;

	localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
	localparam logic [POLICY_W-1:0] POL_LRU  = 2'd1;
	localparam logic [POLICY_W-1:0] POL_LFU  = 2'd2;

	localparam logic [FIU_W-1:0] DEFAULT_FIU = 4'd8;

	localparam logic [CFG_ADDR_W-1:0] REG_POLICY_MODE   = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FRAMES_IN_USE = 1'd1;

	localparam logic REQ_CLEAR = 1'b1;

	typedef struct packed {
		logic [PAGE_W-1:0]  page;
		logic [STAMP_W-1:0] last_use;
		logic [STAMP_W-1:0] load;
		logic [USE_W-1:0]   use_cnt;
	} frame_entry_t;

	typedef struct packed {
		logic match;
		logic better;
	} cmp_res_t;

endpackage

// ----- hw/rtl/prp_frame_mem.sv -----
`timescale 1ns / 1ps

module prp_frame_mem #(
	parameter int FRAMES = prp_pkg::DEFAULT_FRAMES,
	parameter int IDX_W  = 3
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [IDX_W-1:0]     waddr,
	input  prp_pkg::frame_entry_t wdata,
	input  logic [IDX_W-1:0]     raddr,
	output prp_pkg::frame_entry_t rdata
);

	prp_pkg::frame_entry_t mem [FRAMES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/prp_cmp_unit.sv -----
`timescale 1ns / 1ps

module prp_cmp_unit (
	input  prp_pkg::frame_entry_t            entry,
	input  logic                             entry_valid,
	input  logic [prp_pkg::PAGE_W-1:0]       page,
	input  logic [prp_pkg::POLICY_W-1:0]     policy,
	input  prp_pkg::frame_entry_t            best,
	input  logic                             first,
	output prp_pkg::cmp_res_t                res
);

	always_comb begin
		res.match = entry_valid && (entry.page == page);
		case (policy)
			prp_pkg::POL_LRU: begin
				res.better = first || (entry.last_use < best.last_use);
			end
			prp_pkg::POL_LFU: begin
				// lowest use count, ties to the oldest load
				res.better = first || (entry.use_cnt < best.use_cnt) ||
					((entry.use_cnt == best.use_cnt) && (entry.load < best.load));
			end
			default: begin
				res.better = first;
			end
		endcase
	end

endmodule

// ----- hw/rtl/page_replacement_policy_top.sv -----
`timescale 1ns / 1ps

// Page replacement unit with FIFO, LRU and LFU victim selection over up to FRAMES
// frames. An access request walks the managed frames (n = frames_in_use clamped to
// 1..FRAMES) through one frame-table read port, one frame per cycle, while a single
// compare unit checks for a hit and tracks the victim candidate; the result is then
// written back in the UPDATE state. An access occupies the block through the SCAN,
// UPDATE and FINISH states until s_tready returns, a clear request through FINISH
// only; FINISH waits until the result register is free. The frame walk through the
// shared read port sets the length of an access. The result sits in an output register, so the
// next request can be taken while a result waits for m_tready. hit_count and
// fault_count saturate; a clear empties all frames and zeroes the totals and the stamp clock.
module page_replacement_policy_top #(
	parameter int FRAMES = prp_pkg::DEFAULT_FRAMES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [prp_pkg::PAGE_W-1:0]          s_tdata,  // page_number
	input  logic                                s_tuser,  // req_type
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// hit, frame_slot, evicted_valid, evicted_page, hit_count, fault_count, zero pad
	output logic [prp_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic [prp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [prp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W = $clog2(FRAMES + 1);
	localparam logic [7:0] FRAMES_8 = 8'(FRAMES);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		UPDATE,
		FINISH
	} state_t;

	state_t state_q;

	logic [prp_pkg::POLICY_W-1:0] policy_q;
	logic [prp_pkg::FIU_W-1:0]    fiu_q;

	logic [FRAMES-1:0]            valid_q;
	logic [IDX_W-1:0]             ptr_q;
	logic [prp_pkg::STAMP_W-1:0]  clock_q;
	logic [prp_pkg::TOTAL_W-1:0]  hit_tot_q;
	logic [prp_pkg::TOTAL_W-1:0]  flt_tot_q;

	logic [prp_pkg::PAGE_W-1:0]   page_q;
	logic [CNT_W-1:0]             n_q;
	logic [CNT_W-1:0]             addr_q;
	logic                         vld_s1;
	logic [IDX_W-1:0]             idx_s1;

	logic                         found_q;
	logic [IDX_W-1:0]             hit_idx_q;
	prp_pkg::frame_entry_t        hit_ent_q;
	logic                         empty_q;
	logic [IDX_W-1:0]             empty_idx_q;
	logic [IDX_W-1:0]             best_idx_q;
	prp_pkg::frame_entry_t        best_ent_q;
	logic [prp_pkg::PAGE_W-1:0]   fifo_page_q;

	logic                         res_hit_q;
	logic [IDX_W-1:0]             res_slot_q;
	logic                         res_ev_q;
	logic [prp_pkg::PAGE_W-1:0]   res_evp_q;

	logic                         out_hit_q;
	logic [IDX_W-1:0]             out_slot_q;
	logic                         out_ev_q;
	logic [prp_pkg::PAGE_W-1:0]   out_evp_q;
	logic [prp_pkg::TOTAL_W-1:0]  out_hitc_q;
	logic [prp_pkg::TOTAL_W-1:0]  out_fltc_q;
	logic                         m_tvalid_q;

	logic [7:0]                   fiu8;
	logic [7:0]                   n8;
	logic                         in_xact;
	logic                         out_free;
	logic                         scan_issue;
	logic [IDX_W-1:0]             fifo_vic;

	prp_pkg::frame_entry_t        rd_data;
	prp_pkg::frame_entry_t        wr_data;
	prp_pkg::cmp_res_t            cmp;

	logic [IDX_W-1:0]             upd_slot;
	logic                         upd_ev;
	logic [prp_pkg::PAGE_W-1:0]   upd_evp;
	logic [CNT_W-1:0]             slot_inc;
	logic [IDX_W-1:0]             next_ptr;
	logic [IDX_W+2:0]             slot_ext;

	assign fiu8 = {4'd0, fiu_q};
	assign n8 = (fiu8 == 8'd0) ? 8'd1 : ((fiu8 > FRAMES_8) ? FRAMES_8 : fiu8);

	assign s_tready   = (state_q == IDLE);
	assign in_xact    = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign scan_issue = (state_q == SCAN) && (addr_q < n_q);
	assign fifo_vic   = (CNT_W'(ptr_q) < n_q) ? ptr_q : '0;

	prp_frame_mem #(
		.FRAMES (FRAMES),
		.IDX_W  (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (state_q == UPDATE),
		.waddr (upd_slot),
		.wdata (wr_data),
		.raddr (addr_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	prp_cmp_unit u_cmp (
		.entry       (rd_data),
		.entry_valid (valid_q[idx_s1]),
		.page        (page_q),
		.policy      (policy_q),
		.best        (best_ent_q),
		.first       (idx_s1 == '0),
		.res         (cmp)
	);

	// write-back decision once the walk is done
	always_comb begin
		upd_slot = hit_idx_q;
		upd_ev   = 1'b0;
		upd_evp  = '0;
		wr_data.page     = page_q;
		wr_data.last_use = clock_q;
		if (found_q) begin
			wr_data.load    = hit_ent_q.load;
			wr_data.use_cnt = (hit_ent_q.use_cnt != '1) ? hit_ent_q.use_cnt + 1'b1
				: hit_ent_q.use_cnt;
		end else begin
			wr_data.load    = clock_q;
			wr_data.use_cnt = prp_pkg::USE_W'(1);
			if (empty_q) begin
				upd_slot = empty_idx_q;
			end else if (policy_q == prp_pkg::POL_LRU || policy_q == prp_pkg::POL_LFU) begin
				upd_slot = best_idx_q;
				upd_ev   = 1'b1;
				upd_evp  = best_ent_q.page;
			end else begin
				upd_slot = fifo_vic;
				upd_ev   = 1'b1;
				upd_evp  = fifo_page_q;
			end
		end
		slot_inc = CNT_W'(upd_slot) + 1'b1;
		next_ptr = (slot_inc < n_q) ? slot_inc[IDX_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= prp_pkg::POL_FIFO;
			fiu_q    <= prp_pkg::DEFAULT_FIU;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				prp_pkg::REG_POLICY_MODE: begin
					policy_q <= cfg_wdata[prp_pkg::POLICY_W-1:0];
				end
				prp_pkg::REG_FRAMES_IN_USE: begin
					fiu_q <= cfg_wdata[prp_pkg::FIU_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			valid_q     <= '0;
			ptr_q       <= '0;
			clock_q     <= '0;
			hit_tot_q   <= '0;
			flt_tot_q   <= '0;
			page_q      <= '0;
			n_q         <= '0;
			addr_q      <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			found_q     <= 1'b0;
			hit_idx_q   <= '0;
			hit_ent_q   <= '0;
			empty_q     <= 1'b0;
			empty_idx_q <= '0;
			best_idx_q  <= '0;
			best_ent_q  <= '0;
			fifo_page_q <= '0;
			res_hit_q   <= 1'b0;
			res_slot_q  <= '0;
			res_ev_q    <= 1'b0;
			res_evp_q   <= '0;
			out_hit_q   <= 1'b0;
			out_slot_q  <= '0;
			out_ev_q    <= 1'b0;
			out_evp_q   <= '0;
			out_hitc_q  <= '0;
			out_fltc_q  <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			// in finish the output register is reloaded below
			if (m_tvalid_q && m_tready && state_q != FINISH) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_xact) begin
						if (s_tuser == prp_pkg::REQ_CLEAR) begin
							valid_q    <= '0;
							ptr_q      <= '0;
							clock_q    <= '0;
							hit_tot_q  <= '0;
							flt_tot_q  <= '0;
							res_hit_q  <= 1'b0;
							res_slot_q <= '0;
							res_ev_q   <= 1'b0;
							res_evp_q  <= '0;
							state_q    <= FINISH;
						end else begin
							page_q  <= s_tdata;
							n_q     <= n8[CNT_W-1:0];
							addr_q  <= '0;
							vld_s1  <= 1'b0;
							found_q <= 1'b0;
							empty_q <= 1'b0;
							state_q <= SCAN;
						end
					end
				end
				SCAN: begin
					vld_s1 <= scan_issue;
					idx_s1 <= addr_q[IDX_W-1:0];
					if (scan_issue) begin
						addr_q <= addr_q + 1'b1;
					end else if (!vld_s1) begin
						state_q <= UPDATE;
					end
					// frame read last cycle is on rd_data now
					if (vld_s1) begin
						if (!found_q && cmp.match) begin
							found_q   <= 1'b1;
							hit_idx_q <= idx_s1;
							hit_ent_q <= rd_data;
						end
						if (!empty_q && !valid_q[idx_s1]) begin
							empty_q     <= 1'b1;
							empty_idx_q <= idx_s1;
						end
						if (cmp.better) begin
							best_idx_q <= idx_s1;
							best_ent_q <= rd_data;
						end
						if (idx_s1 == fifo_vic) begin
							fifo_page_q <= rd_data.page;
						end
					end
				end
				UPDATE: begin
					clock_q <= clock_q + 1'b1;
					if (found_q) begin
						if (hit_tot_q != '1) begin
							hit_tot_q <= hit_tot_q + 1'b1;
						end
					end else begin
						valid_q[upd_slot] <= 1'b1;
						ptr_q <= next_ptr;
						if (flt_tot_q != '1) begin
							flt_tot_q <= flt_tot_q + 1'b1;
						end
					end
					res_hit_q  <= found_q;
					res_slot_q <= upd_slot;
					res_ev_q   <= upd_ev;
					res_evp_q  <= upd_evp;
					state_q    <= FINISH;
				end
				FINISH: begin
					if (out_free) begin
						out_hit_q  <= res_hit_q;
						out_slot_q <= res_slot_q;
						out_ev_q   <= res_ev_q;
						out_evp_q  <= res_evp_q;
						out_hitc_q <= hit_tot_q;
						out_fltc_q <= flt_tot_q;
						m_tvalid_q <= 1'b1;
						state_q    <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign slot_ext = {3'b000, out_slot_q};
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{prp_pkg::OUT_PAD_W{1'b0}}, out_fltc_q, out_hitc_q, out_evp_q,
		out_ev_q, slot_ext[prp_pkg::SLOT_W-1:0], out_hit_q};

endmodule

// ----- hw/rtl/prp_checker.sv -----
`timescale 1ns / 1ps
`include "page_replacement_policy_top_macros.svh"

module prp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [prp_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// s_tready is low in the cycle after a request is accepted
	`PRP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accept")

	`PRP_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

	// a hit never evicts
	`PRP_ASSERT_NOW(a_hit_no_evict, m_tvalid, !(m_tdata[0] && m_tdata[4]), "hit with eviction")

	`PRP_ASSERT_NOW(a_evict_page_zero, m_tvalid && !m_tdata[4], m_tdata[20:5] == 16'd0, "evicted page set without eviction")

endmodule

bind page_replacement_policy_top prp_checker u_prp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- verif/page_replacement_policy_top_test.sv -----
`timescale 1ns / 1ps

module page_replacement_policy_top_test;
	import prp_pkg::*;

	localparam int FRAMES      = DEFAULT_FRAMES;
	localparam int SETTLE      = 2 * (FRAMES + 4);
	localparam int LONG_HOLD   = 400;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic REQ_ACCESS = 1'b0;

	// fields from the msb down, so the lowest field lands at bit 0
	typedef struct packed {
		logic [TOTAL_W-1:0] fault_count;
		logic [TOTAL_W-1:0] hit_count;
		logic [PAGE_W-1:0]  ev_page;
		logic               ev_valid;
		logic [SLOT_W-1:0]  slot;
		logic               hit;
	} lookup_result_t;

	class frame_table_scoreboard;
		logic [POLICY_W-1:0] policy;
		logic [FIU_W-1:0]    fiu;
		logic [PAGE_W-1:0]   page_at[FRAMES];
		bit                  resident[FRAMES];
		int                  fifo_ptr;
		logic [STAMP_W-1:0]  clock_now;
		logic [STAMP_W-1:0]  last_use[FRAMES];
		logic [STAMP_W-1:0]  loaded_at[FRAMES];
		logic [USE_W-1:0]    use_cnt[FRAMES];
		logic [TOTAL_W-1:0]  hits;
		logic [TOTAL_W-1:0]  faults;
		lookup_result_t      expected_lookups[$];
		int                  errors;
		int                  checked;

		function new();
			policy = POL_FIFO;
			fiu = DEFAULT_FIU;
			errors = 0;
			checked = 0;
			clear_frames();
		endfunction

		function void clear_frames();
			for (int j = 0; j < FRAMES; j++) begin
				page_at[j] = '0;
				resident[j] = 0;
				last_use[j] = '0;
				loaded_at[j] = '0;
				use_cnt[j] = '0;
			end
			fifo_ptr = 0;
			clock_now = '0;
			hits = '0;
			faults = '0;
		endfunction

		function int managed();
			if (fiu == 0)
				return 1;
			return (fiu > FRAMES) ? FRAMES : int'(fiu);
		endfunction

		function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
			if (addr == REG_POLICY_MODE)
				policy = data[POLICY_W-1:0];
			else if (addr == REG_FRAMES_IN_USE)
				fiu = data[FIU_W-1:0];
		endfunction

		function int pending();
			return expected_lookups.size();
		endfunction

		function void note_request(logic req, logic [PAGE_W-1:0] page);
			lookup_result_t r;
			int n;
			int slot;
			bit found;
			bit empty;
			r = '0;
			if (req == REQ_CLEAR) begin
				clear_frames();
				expected_lookups.push_back(r);
				return;
			end
			n = managed();
			slot = 0;
			found = 0;
			empty = 0;
			for (int j = 0; j < n; j++) begin
				if (resident[j] && page_at[j] == page) begin
					found = 1;
					slot = j;
					break;
				end
			end
			if (found) begin
				last_use[slot] = clock_now;
				if (use_cnt[slot] != '1)
					use_cnt[slot]++;
				if (hits != '1)
					hits++;
			end else begin
				for (int j = 0; j < n; j++) begin
					if (!resident[j]) begin
						empty = 1;
						slot = j;
						break;
					end
				end
				if (!empty) begin
					case (policy)
						POL_LRU: begin
							slot = 0;
							for (int j = 1; j < n; j++)
								if (last_use[j] < last_use[slot])
									slot = j;
						end
						POL_LFU: begin
							slot = 0;
							for (int j = 1; j < n; j++) begin
								if (use_cnt[j] < use_cnt[slot])
									slot = j;
								else if (use_cnt[j] == use_cnt[slot] &&
										loaded_at[j] < loaded_at[slot])
									slot = j;
							end
						end
						// fifo, and the unused policy code
						default: slot = (fifo_ptr < n) ? fifo_ptr : 0;
					endcase
					r.ev_valid = 1'b1;
					r.ev_page = page_at[slot];
				end
				page_at[slot] = page;
				resident[slot] = 1;
				last_use[slot] = clock_now;
				loaded_at[slot] = clock_now;
				use_cnt[slot] = 1;
				fifo_ptr = (slot + 1 < n) ? slot + 1 : 0;
				if (faults != '1)
					faults++;
			end
			clock_now++;
			r.hit = found;
			r.slot = slot[SLOT_W-1:0];
			r.hit_count = hits;
			r.fault_count = faults;
			expected_lookups.push_back(r);
		endfunction

		task report(string what, logic [TOTAL_W-1:0] got, logic [TOTAL_W-1:0] want);
			$display("result %0d: %s is %0h, expected %0h", checked, what, got, want);
			errors++;
		endtask

		task check_result(logic [OUT_TDATA_W-1:0] data);
			lookup_result_t got;
			lookup_result_t want;
			got = data[OUT_W-1:0];
			if (expected_lookups.size() == 0) begin
				report("unexpected transaction", got.slot, 0);
			end else begin
				want = expected_lookups.pop_front();
				if (got.hit != want.hit)
					report("hit", got.hit, want.hit);
				if (got.slot != want.slot)
					report("frame_slot", got.slot, want.slot);
				if (got.ev_valid != want.ev_valid)
					report("evicted_valid", got.ev_valid, want.ev_valid);
				if (got.ev_page != want.ev_page)
					report("evicted_page", got.ev_page, want.ev_page);
				if (got.hit_count != want.hit_count)
					report("hit_count", got.hit_count, want.hit_count);
				if (got.fault_count != want.fault_count)
					report("fault_count", got.fault_count, want.fault_count);
			end
			checked++;
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [PAGE_W-1:0]      s_tdata;  // page_number
	logic                   s_tuser;  // req_type
	logic                   m_tvalid;
	logic                   m_tready;
	// hit, frame_slot, evicted_valid, evicted_page, hit_count, fault_count, zero pad
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we;
	logic [CFG_ADDR_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	frame_table_scoreboard sb = new();
	bit steady = 0;
	bit rx_hold_req = 0;
	int cycles = 0;

	page_replacement_policy_top #(.FRAMES(FRAMES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 93)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int rx_wait;
		rx_wait = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 0;
				rx_wait = LONG_HOLD;
			end else if (rx_wait == 0 && !steady && $urandom_range(0, 3) == 0) begin
				rx_wait = idle_len();
			end
			if (rx_wait > 0) begin
				m_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_item(logic req, logic [PAGE_W-1:0] page);
		int g;
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= page;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(req, page);
		g = (!steady && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(addr, data);
	endtask

	task automatic set_policy(logic [POLICY_W-1:0] pol);
		write_reg(REG_POLICY_MODE, {2'($urandom_range(0, 3)), pol});
	endtask

	task automatic access(logic [PAGE_W-1:0] page);
		send_item(REQ_ACCESS, page);
	endtask

	// requests drawn mostly from a small pool of pages so that hits and evictions happen
	task automatic run_phase(int count, bit drain_mid);
		logic [PAGE_W-1:0] pool[16];
		int psize;
		int r;
		psize = $urandom_range(1, sb.managed() + 6);
		for (int j = 0; j < psize; j++)
			pool[j] = PAGE_W'($urandom);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (drain_mid && i == count / 2)
				wait_idle();
			if (r < 2)
				send_item(REQ_CLEAR, PAGE_W'($urandom));
			else if (r < 10)
				access(PAGE_W'($urandom));
			else
				access(pool[$urandom_range(0, psize - 1)]);
		end
	endtask

	initial begin
		logic [FIU_W-1:0] fiu_pick[6];
		fiu_pick = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd2};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = REQ_ACCESS;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = REG_POLICY_MODE;
		cfg_wdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme pages, a hit, a clear
		access(16'h0000);
		access(16'hFFFF);
		access(16'h0000);
		send_item(REQ_CLEAR, 16'hA5A5);
		access(16'hFFFF);
		for (int p = 1; p <= 5; p++)
			access(p[PAGE_W-1:0]);
		// shrink to three frames: fifo pointer now past the managed range
		write_reg(REG_FRAMES_IN_USE, 4'd3);
		access(16'd7);
		// zero frames clamps to one
		write_reg(REG_FRAMES_IN_USE, 4'd0);
		access(16'd9);
		access(16'd9);
		// oversized count clamps to all frames; page 2 still sits past the old range
		write_reg(REG_FRAMES_IN_USE, 4'd15);
		access(16'd2);
		// unused policy code behaves as fifo
		set_policy(2'd3);
		access(16'd100);
		access(16'd101);
		access(16'd102);
		set_policy(POL_LRU);
		access(16'd200);
		set_policy(POL_LFU);
		access(16'd201);

		for (int p = 0; p < 14; p++) begin
			set_policy((p < 4) ? 2'(p) : 2'($urandom_range(0, 3)));
			write_reg(REG_FRAMES_IN_USE,
				(p < 6) ? fiu_pick[p] : 4'($urandom_range(0, 15)));
			if ($urandom_range(0, 1) == 0)
				send_item(REQ_CLEAR, PAGE_W'($urandom));
			steady = (p % 5 == 2);
			// receiver holds off while requests keep coming
			if (p == 1)
				rx_hold_req = 1;
			run_phase(125, p == 3);
		end
		steady = 0;

		wait_idle();
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- page_replacement_policy_top.f -----
+incdir+hw/rtl
hw/rtl/prp_pkg.sv
hw/rtl/prp_frame_mem.sv
hw/rtl/prp_cmp_unit.sv
hw/rtl/page_replacement_policy_top.sv
hw/rtl/prp_checker.sv
verif/page_replacement_policy_top_test.sv
